// ----- src/agrse_pkg.sv -----
// ----------------------------------------------------------------------------
// agrse_pkg
// Shared widths, reset constants and stage payload types of the adaptive
// Golomb-Rice size estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package agrse_pkg;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned SPLIT_W   = 4;
    localparam int unsigned HIGH_W    = 15;
    localparam int unsigned K_W       = 5;
    localparam int unsigned K_MAX     = 16;
    localparam int unsigned Q_W       = 15;
    localparam int unsigned REM_W     = 17;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned BITS_W    = 40;
    localparam int unsigned SAMPLES_W = 32;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned PROD_W    = SPLIT_W + SAMPLES_W;
    localparam int unsigned SCALED_W  = COUNT_W + K_MAX;

    localparam logic [COUNT_W-1:0] COUNT_INIT  = 8'd1;
    localparam logic [SUM_W-1:0]   SUM_INIT    = 16'd8;
    localparam logic [SPLIT_W-1:0] SPLIT_RESET = 4'd5;

    // Output of the statistics stage.
    typedef struct packed {
        logic [HIGH_W-1:0]    high;
        logic [K_W-1:0]       rice_k;
        logic [SPLIT_W-1:0]   split;
        logic [SAMPLES_W-1:0] sample_total;
        logic                 last_sample;
    } agrse_stats_t;

    // Output of the coding stage.
    typedef struct packed {
        logic [Q_W-1:0]    quotient;
        logic [REM_W-1:0]  remainder_code;
        logic [K_W-1:0]    rice_k;
        logic [LEN_W-1:0]  code_length;
        logic [BITS_W-1:0] running_bits;
        logic [PROD_W-1:0] split_product;
        logic              last_sample;
    } agrse_code_t;

    // Final result as presented on the result channel.
    typedef struct packed {
        logic [Q_W-1:0]    quotient;
        logic [REM_W-1:0]  remainder_code;
        logic [K_W-1:0]    rice_k;
        logic [LEN_W-1:0]  code_length;
        logic [BITS_W-1:0] running_bits;
        logic [BITS_W-1:0] block_bytes;
        logic              block_done;
    } agrse_result_t;

endpackage

`default_nettype wire

// ----- src/agrse_if.sv -----
// ----------------------------------------------------------------------------
// agrse interfaces
// Valid/ready channels for samples, results and the split_bits register.
// ----------------------------------------------------------------------------
`default_nettype none

interface agrse_sample_if import agrse_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface agrse_result_if import agrse_pkg::*;;
    logic              valid;
    logic              ready;
    logic [Q_W-1:0]    quotient;
    logic [REM_W-1:0]  remainder_code;
    logic [K_W-1:0]    rice_k;
    logic [LEN_W-1:0]  code_length;
    logic [BITS_W-1:0] running_bits;
    logic [BITS_W-1:0] block_bytes;
    logic              block_done;

    modport source (output valid, output quotient, output remainder_code, output rice_k,
                    output code_length, output running_bits, output block_bytes,
                    output block_done, input ready);
    modport sink   (input valid, input quotient, input remainder_code, input rice_k,
                    input code_length, input running_bits, input block_bytes,
                    input block_done, output ready);
endinterface

interface agrse_cfg_if import agrse_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SPLIT_W-1:0] split_bits;

    modport source (output valid, output split_bits, input ready);
    modport sink   (input valid, input split_bits, output ready);
endinterface

`default_nettype wire

// ----- src/adaptive_golomb_rice_size_estimator.sv -----
// ----------------------------------------------------------------------------
// adaptive_golomb_rice_size_estimator
// Streams 16-bit samples through adaptive Golomb-Rice coding of their high
// part and estimates the coded size of each block.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the samples channel, one request per sample, with
// last_sample marking the final sample of a block. Each request yields one
// request on the results channel carrying the quotient, the binary part, k,
// the code length and the running bit total; the request that closes a block
// also carries the byte estimate and block_done.
// The split_bits register is written through the cfg channel, which is always
// ready; write it only while no sample is in flight.
// Throughput is one sample per cycle while the receiver does not stall. The
// path is four register stages deep (input, statistics, coder, result). The
// feedback loop that sets this rate is the statistics stage: the k compare
// and the count/sum update both read and write count_reg and sum_reg.
// Reset clears all stages, sets split_bits to 5 and the statistics to a
// count of one and a sum of eight. When the receiver stalls, each stage
// holds its item and fills bubbles ahead of it, so samples are still taken
// until every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_golomb_rice_size_estimator import agrse_pkg::*;
#(
    parameter int unsigned HALVE_AT = 128
)
(
    input  wire             clk,
    input  wire             rst_n,
    agrse_sample_if.sink    samples,
    agrse_result_if.source  results,
    agrse_cfg_if.sink       cfg
);

    logic [SPLIT_W-1:0]  split_reg;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;

    logic          stats_in_ready;
    logic          stats_valid;
    agrse_stats_t  stats_data;
    logic          coder_in_ready;
    logic          coder_valid;
    agrse_code_t   coder_data;
    logic          est_in_ready;
    agrse_result_t result_data;

    // The register port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_reg <= SPLIT_RESET;
        end
        else if (cfg.valid)
        begin
            split_reg <= cfg.split_bits;
        end
    end

    // Input register: takes a new sample whenever it is empty or draining.
    assign samples.ready = !in_valid_reg || stats_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            sample_reg <= samples.sample;
            last_reg   <= samples.last_sample;
        end
    end

    agrse_stats #(
        .HALVE_AT (HALVE_AT)
    ) u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid_reg),
        .in_ready    (stats_in_ready),
        .sample      (sample_reg),
        .last_sample (last_reg),
        .split_bits  (split_reg),
        .out_valid   (stats_valid),
        .out_ready   (coder_in_ready),
        .out_data    (stats_data)
    );

    agrse_coder u_coder (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stats_valid),
        .in_ready  (coder_in_ready),
        .in_data   (stats_data),
        .out_valid (coder_valid),
        .out_ready (est_in_ready),
        .out_data  (coder_data)
    );

    agrse_estimate u_estimate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coder_valid),
        .in_ready  (est_in_ready),
        .in_data   (coder_data),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (result_data)
    );

    assign results.quotient       = result_data.quotient;
    assign results.remainder_code = result_data.remainder_code;
    assign results.rice_k         = result_data.rice_k;
    assign results.code_length    = result_data.code_length;
    assign results.running_bits   = result_data.running_bits;
    assign results.block_bytes    = result_data.block_bytes;
    assign results.block_done     = result_data.block_done;

endmodule

`default_nettype wire

// ----- src/agrse_stats.sv -----
// ----------------------------------------------------------------------------
// agrse_stats
// Selects k from the running statistics and updates count, sum and the
// sample count of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module agrse_stats import agrse_pkg::*;
#(
    parameter int unsigned HALVE_AT = 128
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire [SAMPLE_W-1:0]  sample,
    input  wire                 last_sample,
    input  wire [SPLIT_W-1:0]   split_bits,
    output logic                out_valid,
    input  wire                 out_ready,
    output agrse_stats_t        out_data
);

    logic [COUNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SAMPLES_W-1:0] total_reg;
    logic                 valid_reg;
    agrse_stats_t         data_reg;

    logic [SPLIT_W-1:0]   split_eff;
    logic [SAMPLE_W-1:0]  high_full;
    logic [HIGH_W-1:0]    high;
    logic [K_W-1:0]       k_sel;
    logic                 halve;
    logic [COUNT_W-1:0]   count_base;
    logic [SUM_W-1:0]     sum_base;
    logic [SUM_W:0]       sum_wide;
    logic [SUM_W-1:0]     sum_sat;
    logic [COUNT_W-1:0]   count_inc;
    logic [SAMPLES_W-1:0] total_inc;
    logic                 fire;

    assign split_eff = (split_bits == '0) ? SPLIT_W'(1) : split_bits;
    assign high_full = sample >> split_eff;
    assign high      = high_full[HIGH_W-1:0];

    // Least k with count << k at or above the sum; all shifts compared at once.
    always_comb
    begin
        logic [SCALED_W-1:0] scaled;
        k_sel  = K_W'(K_MAX);
        scaled = '0;
        for (int j = K_MAX - 1; j >= 0; j--)
        begin
            scaled = SCALED_W'(count_reg) << j;
            if (count_reg != '0 && scaled >= SCALED_W'(sum_reg))
            begin
                k_sel = K_W'(j);
            end
        end
    end

    assign halve      = (count_reg == COUNT_W'(HALVE_AT));
    assign count_base = halve ? (count_reg >> 1) : count_reg;
    assign sum_base   = halve ? (sum_reg >> 1) : sum_reg;
    assign sum_wide   = {1'b0, sum_base} + (SUM_W + 1)'(high);
    assign sum_sat    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    assign count_inc  = count_base + COUNT_W'(1);
    assign total_inc  = total_reg + SAMPLES_W'(1);

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_INIT;
            sum_reg   <= SUM_INIT;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (fire)
            begin
                if (last_sample)
                begin
                    count_reg <= COUNT_INIT;
                    sum_reg   <= SUM_INIT;
                    total_reg <= '0;
                end
                else
                begin
                    count_reg <= count_inc;
                    sum_reg   <= sum_sat;
                    total_reg <= total_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg.high         <= high;
            data_reg.rice_k       <= k_sel;
            data_reg.split        <= split_eff;
            data_reg.sample_total <= total_inc;
            data_reg.last_sample  <= last_sample;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/agrse_coder.sv -----
// ----------------------------------------------------------------------------
// agrse_coder
// Forms the Golomb-Rice quotient, binary part and code length, and keeps
// the running bit total of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module agrse_coder import agrse_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           in_valid,
    output logic          in_ready,
    input  agrse_stats_t  in_data,
    output logic          out_valid,
    input  wire           out_ready,
    output agrse_code_t   out_data
);

    logic [BITS_W-1:0] bit_total_reg;
    logic              valid_reg;
    agrse_code_t       data_reg;

    logic [Q_W-1:0]    quotient;
    logic [REM_W-1:0]  k_bit;
    logic [REM_W-1:0]  remainder_code;
    logic [LEN_W-1:0]  code_length;
    logic [BITS_W-1:0] running;
    logic [PROD_W-1:0] split_product;
    logic              fire;

    assign quotient       = Q_W'(in_data.high >> in_data.rice_k);
    assign k_bit          = REM_W'(1) << in_data.rice_k;
    assign remainder_code = k_bit | (REM_W'(in_data.high) & (k_bit - REM_W'(1)));
    assign code_length    = LEN_W'(quotient) + LEN_W'(1) + LEN_W'(in_data.rice_k);
    assign running        = bit_total_reg + BITS_W'(code_length);
    assign split_product  = PROD_W'(in_data.split) * PROD_W'(in_data.sample_total);

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_total_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (fire)
            begin
                bit_total_reg <= in_data.last_sample ? '0 : running;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg.quotient       <= quotient;
            data_reg.remainder_code <= remainder_code;
            data_reg.rice_k         <= in_data.rice_k;
            data_reg.code_length    <= code_length;
            data_reg.running_bits   <= running;
            data_reg.split_product  <= split_product;
            data_reg.last_sample    <= in_data.last_sample;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/agrse_estimate.sv -----
// ----------------------------------------------------------------------------
// agrse_estimate
// Rounds the coded bits and the dropped low bits up to bytes on the closing
// sample and holds the final result register.
// ----------------------------------------------------------------------------
`default_nettype none

module agrse_estimate import agrse_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  agrse_code_t    in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output agrse_result_t  out_data
);

    logic          valid_reg;
    agrse_result_t data_reg;

    logic [BITS_W-1:0] code_bytes;
    logic [BITS_W-1:0] split_bytes;
    logic [BITS_W-1:0] block_bytes;
    logic              fire;

    assign code_bytes  = BITS_W'(in_data.running_bits >> 3)
                       + BITS_W'(in_data.running_bits[2:0] != 3'd0);
    assign split_bytes = BITS_W'(in_data.split_product >> 3)
                       + BITS_W'(in_data.split_product[2:0] != 3'd0);
    assign block_bytes = in_data.last_sample ? (code_bytes + split_bytes) : '0;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg.quotient       <= in_data.quotient;
            data_reg.remainder_code <= in_data.remainder_code;
            data_reg.rice_k         <= in_data.rice_k;
            data_reg.code_length    <= in_data.code_length;
            data_reg.running_bits   <= in_data.running_bits;
            data_reg.block_bytes    <= block_bytes;
            data_reg.block_done     <= in_data.last_sample;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/agrse_checker.sv -----
// ----------------------------------------------------------------------------
// agrse_checker
// Port-level checks on the result channel of the size estimator.
// ----------------------------------------------------------------------------
`default_nettype none

module agrse_checker
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        valid,
    input  wire        ready,
    input  wire [14:0] quotient,
    input  wire [16:0] remainder_code,
    input  wire [4:0]  rice_k,
    input  wire [15:0] code_length,
    input  wire [39:0] running_bits,
    input  wire [39:0] block_bytes,
    input  wire        block_done
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result request dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(code_length) && $stable(running_bits)
                            && $stable(block_done))
        else $error("result payload changed while stalled");

    a_bytes_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !block_done |-> block_bytes == 40'd0)
        else $error("byte estimate shown on a sample that does not close the block");

    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> code_length == 16'(quotient) + 16'd1 + 16'(rice_k))
        else $error("code length disagrees with quotient and k");

    a_binary_part: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> rice_k <= 5'd16 && (remainder_code >> rice_k) == 17'd1)
        else $error("binary part does not lead with a single one at bit k");

endmodule

bind adaptive_golomb_rice_size_estimator agrse_checker u_agrse_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (results.valid),
    .ready          (results.ready),
    .quotient       (results.quotient),
    .remainder_code (results.remainder_code),
    .rice_k         (results.rice_k),
    .code_length    (results.code_length),
    .running_bits   (results.running_bits),
    .block_bytes    (results.block_bytes),
    .block_done     (results.block_done)
);

`default_nettype wire
